// ===== rtl/nsm_pkg.sv =====
// Package for the nested scope matcher: line and record kind codes, field widths
// and the push/pop command struct shared by the stack cells.
// No dependencies.
package nsm_pkg;

  localparam int unsigned LINE_FIELD_W = 16;
  localparam int unsigned LEVEL_W      = 8;
  localparam int unsigned LEVEL_MAX    = 255;

  typedef enum logic [1:0] {
    LK_OTHER = 2'd0,
    LK_OPEN  = 2'd1,
    LK_CLOSE = 2'd2,
    LK_END   = 2'd3
  } line_kind_e;

  typedef enum logic [2:0] {
    RK_SCOPE    = 3'd0,
    RK_ROOT     = 3'd1,
    RK_TOO_DEEP = 3'd2,
    RK_NO_OPEN  = 3'd3,
    RK_UNCLOSED = 3'd4
  } record_kind_e;

  typedef struct packed {
    logic push;
    logic pop;
  } stack_op_t;

endpackage

// ===== rtl/nsm_cell.sv =====
// One entry of the shifting scope stack: holds a first-line number and takes
// its neighbour's value on push or pop. Depends on nsm_pkg.
module nsm_cell
  import nsm_pkg::*;
#(
  parameter int unsigned LINE_W = 16
) (
  input  logic              clk_i,
  input  stack_op_t         op_i,
  input  logic [LINE_W-1:0] above_i,
  input  logic [LINE_W-1:0] below_i,
  output logic [LINE_W-1:0] value_o
);

  logic [LINE_W-1:0] value_q, value_d;

  always_comb begin
    value_d = value_q;
    if (op_i.push) begin
      value_d = above_i;
    end else if (op_i.pop) begin
      value_d = below_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

// ===== rtl/nested_scope_matcher.sv =====
// Nested scope matcher: a record appears on m_axis in the cycle after the line word
// that causes it is accepted; one line word per cycle while m_axis is not stalled.
// The open-scope stack is a row of STACK_DEPTH-1 shifting cells, top in cell 0,
// so every push and pop completes in the cycle the word is taken.
// Reset clears depth, program flags and the output valid; stack cells are not cleared.
// Depends on nsm_pkg and nsm_cell.
module nested_scope_matcher
  import nsm_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 256,
  parameter int unsigned LINE_BITS   = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] line_number
  input  logic [1:0]  s_axis_tuser,   // [1:0] line_kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [15:0] open line, [31:16] close line, [39:32] nest_level
  output logic [2:0]  m_axis_tuser,   // [2:0] record_kind
  output logic        m_axis_tlast    // set on every record but a scope record
);

  localparam int unsigned LINE_W = (LINE_BITS < LINE_FIELD_W) ? LINE_BITS : LINE_FIELD_W;
  localparam int unsigned NCELL  = STACK_DEPTH - 1;
  localparam int unsigned DW     = (STACK_DEPTH > 2) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned LW     = DW + 1;

  line_kind_e        kind;
  logic [LINE_W-1:0] line;
  logic              acc;
  stack_op_t         op;
  logic [LINE_W-1:0] cell_q [NCELL];
  logic [LINE_W-1:0] above_w [NCELL];
  logic [LINE_W-1:0] below_w [NCELL];

  logic [DW-1:0]     depth_q, depth_d;
  logic              err_q, err_d;
  logic              fs_q, fs_d;
  logic [LINE_W-1:0] pfl_q, pfl_d;

  logic              res_vld;
  record_kind_e      res_kind;
  logic [LINE_W-1:0] res_first, res_last;
  logic [LW-1:0]     res_lvl_src;
  logic              res_done;
  logic [31:0]       lvl_wide;
  logic [LEVEL_W-1:0] res_lvl;

  logic              mv_q, mv_d;
  record_kind_e      m_kind_q;
  logic [LINE_W-1:0] m_first_q, m_last_q;
  logic [LEVEL_W-1:0] m_lvl_q;
  logic              m_done_q;

  assign kind          = line_kind_e'(s_axis_tuser);
  assign line          = s_axis_tdata[LINE_W-1:0];
  assign s_axis_tready = !mv_q || m_axis_tready;
  assign acc           = s_axis_tvalid && s_axis_tready;

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    if (i == 0) begin : g_top
      assign above_w[i] = line;
    end else begin : g_mid
      assign above_w[i] = cell_q[i-1];
    end
    if (i == NCELL - 1) begin : g_bot
      assign below_w[i] = cell_q[i];
    end else begin : g_nbot
      assign below_w[i] = cell_q[i+1];
    end
    nsm_cell #(.LINE_W(LINE_W)) u_cell (
      .clk_i   (clk_i),
      .op_i    (op),
      .above_i (above_w[i]),
      .below_i (below_w[i]),
      .value_o (cell_q[i])
    );
  end

  always_comb begin
    op          = '0;
    depth_d     = depth_q;
    err_d       = err_q;
    fs_d        = fs_q;
    pfl_d       = pfl_q;
    res_vld     = 1'b0;
    res_kind    = RK_SCOPE;
    res_first   = line;
    res_last    = line;
    res_lvl_src = '0;
    res_done    = 1'b1;
    if (acc) begin
      if (kind == LK_END) begin
        if (!err_q) begin
          res_vld = 1'b1;
          if (depth_q == '0) begin
            res_kind  = RK_ROOT;
            res_first = fs_q ? pfl_q : line;
          end else begin
            res_kind    = RK_UNCLOSED;
            res_first   = cell_q[0];
            res_lvl_src = LW'(depth_q);
          end
        end
        depth_d = '0;
        err_d   = 1'b0;
        fs_d    = 1'b0;
        pfl_d   = '0;
      end else if (!err_q) begin
        if (!fs_q) begin
          fs_d  = 1'b1;
          pfl_d = line;
        end
        case (kind)
          LK_OPEN: begin
            if (depth_q == DW'(STACK_DEPTH - 1)) begin
              res_vld     = 1'b1;
              res_kind    = RK_TOO_DEEP;
              res_lvl_src = LW'(STACK_DEPTH);
              err_d       = 1'b1;
            end else begin
              op.push = 1'b1;
              depth_d = depth_q + DW'(1);
            end
          end
          LK_CLOSE: begin
            res_vld = 1'b1;
            if (depth_q == '0) begin
              res_kind = RK_NO_OPEN;
              err_d    = 1'b1;
            end else begin
              res_kind    = RK_SCOPE;
              res_first   = cell_q[0];
              res_lvl_src = LW'(depth_q);
              res_done    = 1'b0;
              op.pop      = 1'b1;
              depth_d     = depth_q - DW'(1);
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign lvl_wide = 32'(res_lvl_src);
  assign res_lvl  = (lvl_wide > 32'(LEVEL_MAX)) ? LEVEL_W'(LEVEL_MAX) : LEVEL_W'(lvl_wide);
  assign mv_d     = res_vld || (mv_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= '0;
      err_q   <= 1'b0;
      fs_q    <= 1'b0;
      pfl_q   <= '0;
      mv_q    <= 1'b0;
    end else begin
      depth_q <= depth_d;
      err_q   <= err_d;
      fs_q    <= fs_d;
      pfl_q   <= pfl_d;
      mv_q    <= mv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_vld) begin
      m_kind_q  <= res_kind;
      m_first_q <= res_first;
      m_last_q  <= res_last;
      m_lvl_q   <= res_lvl;
      m_done_q  <= res_done;
    end
  end

  assign m_axis_tvalid = mv_q;
  assign m_axis_tdata  = {m_lvl_q, LINE_FIELD_W'(m_last_q), LINE_FIELD_W'(m_first_q)};
  assign m_axis_tuser  = m_kind_q;
  assign m_axis_tlast  = m_done_q;

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking bench for nested_scope_matcher: streams classified line words,
// predicts every scope, root and error record and checks m_axis word by word.
// Depends on nsm_pkg and the nested_scope_matcher RTL.
module tb_top;
  import nsm_pkg::*;

  localparam int unsigned STACK_N    = 256;
  localparam int unsigned QUIET_MAX  = 3000;
  localparam int unsigned HOLD_LEN   = 300;
  localparam int unsigned RANDOM_END = 600;

  typedef struct {
    line_kind_e  kind;
    logic [15:0] line;
    int          phase;
    bit          hold;
    bit          drain;
  } line_word_t;

  typedef struct {
    record_kind_e kind;
    logic [15:0]  first;
    logic [15:0]  last;
    logic [7:0]   level;
    logic         done;
  } scope_rec_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = LK_OTHER;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;

  line_word_t  line_words[$];
  scope_rec_t  due_records[$];
  line_word_t  cur_word;
  int unsigned words_queued;
  int unsigned words_sent;
  int unsigned records_seen;
  int unsigned kind_seen[5];
  int unsigned errors;
  int unsigned quiet;
  int          rx_phase = 0;
  logic        hold_req = 1'b0;
  logic        drained = 1'b1;
  bit          deep_done = 1'b0;

  logic [15:0] open_lines[STACK_N];
  int unsigned open_depth;
  logic [15:0] prog_first;
  bit          prog_started;
  bit          dropping;

  nested_scope_matcher #(
    .STACK_DEPTH(STACK_N),
    .LINE_BITS  (16)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always #10 clk_i = ~clk_i;

  function automatic int idle_pct(int ph, bit rx);
    if (ph == 3) return 10;
    if ((ph == 1 && !rx) || (ph == 2 && rx)) return 71;
    return 0;
  endfunction

  function automatic logic [7:0] level_of(int unsigned d);
    return (d > LEVEL_MAX) ? 8'(LEVEL_MAX) : 8'(d);
  endfunction

  task automatic match_line(input line_kind_e lk, input logic [15:0] ln);
    scope_rec_t r;
    bit         emit;
    emit = 1'b0;
    r.first = ln;
    r.last  = ln;
    r.level = '0;
    r.done  = 1'b1;
    r.kind  = RK_SCOPE;
    if (lk == LK_END) begin
      if (!dropping) begin
        emit = 1'b1;
        if (open_depth == 0) begin
          r.kind  = RK_ROOT;
          r.first = prog_started ? prog_first : ln;
        end else begin
          r.kind  = RK_UNCLOSED;
          r.first = open_lines[open_depth - 1];
          r.level = level_of(open_depth);
        end
      end
      open_depth   = 0;
      prog_started = 1'b0;
      dropping     = 1'b0;
    end else if (!dropping) begin
      if (!prog_started) begin
        prog_started = 1'b1;
        prog_first   = ln;
      end
      case (lk)
        LK_OPEN: begin
          if (open_depth + 1 >= STACK_N) begin
            emit     = 1'b1;
            r.kind   = RK_TOO_DEEP;
            r.level  = level_of(open_depth + 1);
            dropping = 1'b1;
          end else begin
            open_lines[open_depth] = ln;
            open_depth++;
          end
        end
        LK_CLOSE: begin
          emit = 1'b1;
          if (open_depth == 0) begin
            r.kind   = RK_NO_OPEN;
            dropping = 1'b1;
          end else begin
            r.level = level_of(open_depth);
            open_depth--;
            r.first = open_lines[open_depth];
            r.done  = 1'b0;
          end
        end
        default: ;
      endcase
    end
    if (emit) due_records.push_back(r);
  endtask

  task automatic queue_line(input line_kind_e lk, input logic [15:0] ln);
    line_word_t w;
    w.kind  = lk;
    w.line  = ln;
    w.phase = (words_queued / 100) % 4;
    w.hold  = (words_queued == 40);
    w.drain = (words_queued == 330 || words_queued == 700);
    line_words.push_back(w);
    words_queued++;
  endtask

  function automatic logic [15:0] any_line();
    return 16'($urandom_range(0, 16'hFFFF));
  endfunction

  task automatic random_program(input bit noisy);
    int unsigned opened;
    int unsigned len;
    int unsigned pick;
    opened = 0;
    len = $urandom_range(1, 30);
    repeat (len) begin
      pick = $urandom_range(0, 99);
      if (noisy) begin
        queue_line(line_kind_e'($urandom_range(0, 3)), any_line());
      end else if (pick < 35) begin
        queue_line(LK_OPEN, any_line());
        opened++;
      end else if (pick < 65 && opened > 0) begin
        queue_line(LK_CLOSE, any_line());
        opened--;
      end else begin
        queue_line(LK_OTHER, any_line());
      end
    end
    if (!noisy && $urandom_range(0, 9) != 0) begin
      repeat (opened) queue_line(LK_CLOSE, any_line());
    end
    queue_line(LK_END, any_line());
  endtask

  task automatic deep_program(input bit overflow);
    repeat (STACK_N - 1) queue_line(LK_OPEN, any_line());
    if (overflow) begin
      queue_line(LK_CLOSE, any_line());
      queue_line(LK_OPEN, any_line());
      queue_line(LK_OPEN, any_line());
      queue_line(LK_CLOSE, any_line());
      queue_line(LK_OTHER, any_line());
    end
    queue_line(LK_END, any_line());
  endtask

  // driver: hold the word until taken, then offer the next or idle
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= LK_OTHER;
    end else begin
      if (s_axis_tvalid && s_axis_tready) words_sent++;
      if (!s_axis_tvalid || s_axis_tready) begin
        if (line_words.size() != 0
            && !(line_words[0].drain && !(drained && !(s_axis_tvalid && s_axis_tready)))
            && $urandom_range(0, 99) >= idle_pct(line_words[0].phase, 1'b0)) begin
          cur_word = line_words.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= cur_word.line;
          s_axis_tuser  <= cur_word.kind;
          rx_phase      <= cur_word.phase;
          if (cur_word.hold) hold_req <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: check records, predict from accepted line words, drive tready
  int unsigned hold_left = 0;
  bit          hold_taken = 1'b0;
  always @(posedge clk_i or negedge rst_ni) begin
    scope_rec_t got;
    scope_rec_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      drained       <= 1'b1;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.kind  = record_kind_e'(m_axis_tuser);
        got.first = m_axis_tdata[15:0];
        got.last  = m_axis_tdata[31:16];
        got.level = m_axis_tdata[39:32];
        got.done  = m_axis_tlast;
        records_seen++;
        if (m_axis_tuser < 5) kind_seen[m_axis_tuser]++;
        if (due_records.size() == 0) begin
          errors++;
          $display("%0t: unexpected record kind %0d first %0d last %0d level %0d done %0b",
                   $time, got.kind, got.first, got.last, got.level, got.done);
        end else begin
          want = due_records.pop_front();
          if (got.kind !== want.kind || got.first !== want.first || got.last !== want.last
              || got.level !== want.level || got.done !== want.done) begin
            errors++;
            $display("%0t: mismatch expected kind %0d first %0d last %0d level %0d done %0b",
                     $time, want.kind, want.first, want.last, want.level, want.done);
            $display("%0t:          actual   kind %0d first %0d last %0d level %0d done %0b",
                     $time, got.kind, got.first, got.last, got.level, got.done);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        match_line(line_kind_e'(s_axis_tuser), s_axis_tdata);
      drained <= (due_records.size() == 0);
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = HOLD_LEN;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= idle_pct(rx_phase, 1'b1));
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= QUIET_MAX) begin
        $display("%0t: no word moved for %0d cycles", $time, quiet);
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    open_depth   = 0;
    prog_started = 1'b0;
    dropping     = 1'b0;
    prog_first   = '0;
    words_queued = 0;
    words_sent   = 0;
    records_seen = 0;
    errors       = 0;
    quiet        = 0;
    foreach (kind_seen[k]) kind_seen[k] = 0;

    queue_line(LK_END, 16'hFFFF);
    queue_line(LK_OTHER, 16'h0000);
    queue_line(LK_OPEN, 16'h0001);
    queue_line(LK_OPEN, 16'h0002);
    queue_line(LK_CLOSE, 16'h0003);
    queue_line(LK_OTHER, 16'hFFFF);
    queue_line(LK_CLOSE, 16'h0004);
    queue_line(LK_END, 16'h0005);
    queue_line(LK_CLOSE, 16'h00AA);
    queue_line(LK_OPEN, 16'h5555);
    queue_line(LK_CLOSE, 16'hAAAA);
    queue_line(LK_END, 16'h000C);
    queue_line(LK_OPEN, 16'hFFFF);
    queue_line(LK_OPEN, 16'h8000);
    queue_line(LK_END, 16'h7FFF);
    queue_line(LK_END, 16'h0000);

    while (words_queued < RANDOM_END) begin
      random_program($urandom_range(0, 99) < 20);
      if (!deep_done && words_queued > 60) begin
        deep_done = 1'b1;
        deep_program(1'b1);
        deep_program(1'b0);
      end
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (line_words.size() != 0 || s_axis_tvalid || due_records.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    if (due_records.size() != 0) begin
      errors++;
      $display("%0t: %0d expected records never arrived", $time, due_records.size());
    end
    $display("Sent %0d line words, checked %0d records: %0d scope, %0d root,",
             words_sent, records_seen, kind_seen[RK_SCOPE], kind_seen[RK_ROOT]);
    $display("  %0d too deep, %0d close without open, %0d unclosed at end.",
             kind_seen[RK_TOO_DEEP], kind_seen[RK_NO_OPEN], kind_seen[RK_UNCLOSED]);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
